// ===== hw/rtl/sha_bsh_pkg.sv =====
// Package: payload types, control struct, constants and SHA-256 round functions.
`timescale 1ns / 1ps

package sha_bsh_pkg;

	// Field widths and counters
	localparam int FILL_W  = 6;
	localparam int MSG_W   = 61;
	localparam int LEN_W   = 64;
	localparam int ROUND_W = 6;
	localparam int CNT_W   = 4;

	localparam logic [FILL_W-1:0]  LEN_POS    = 6'd56;
	localparam logic [FILL_W-1:0]  LAST_FILL  = 6'd63;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
	localparam logic [7:0]         PAD_BYTE   = 8'h80;
	localparam logic [CNT_W-1:0]   DIGEST_WORDS = 4'd8;
	localparam logic [2:0]         LAST_INDEX = 3'd7;

	// Item kinds
	localparam logic KIND_ABSORB = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Initial hash values, element i is hash word i
	localparam logic [7:0][31:0] HASH_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} word_t;

	// Sequencer to datapath commands
	typedef struct packed {
		logic               shift_en;
		logic [7:0]         shift_byte;
		logic               load_vars;
		logic               round_en;
		logic [ROUND_W-1:0] round_idx;
		logic               fold_en;
		logic               init_hash;
	} dp_cmd_t;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] f_ch(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] f_maj(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

	// Round constants
	function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== hw/rtl/sha256_byte_stream_hasher_core.sv =====
// Top level: SHA-256 byte stream hasher with digest word output buffer.
//
//  channel | signals                        | direction | moves
//  item    | item_valid, item_ready, item   | in        | absorb byte or finish
//  word    | word_valid, word_ready, word   | out       | one 32-bit digest word
//
// An absorb byte shifts in when accepted; the byte that fills a block also loads the
// working variables and starts 64 rounds on the shared round unit, then one fold;
// no item is taken meanwhile. A finish shifts in 9 to 72 pad bytes one per cycle, runs
// one or two compressions, then loads the digest into the word buffer, eight words out.
// Reset clears the sequencer, counters and hash words; the block buffer is not cleared.
// A stalled word side only holds a finish in its last step until the buffer drains.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_core import sha_bsh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  word_valid,
	input  logic  word_ready,
	output word_t word
);

	dp_cmd_t          cmd;
	logic [7:0][31:0] digest;
	logic [7:0][31:0] buf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]       idx_q;
	logic             out_busy;

	sha_bsh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_busy   (out_busy),
		.cmd        (cmd)
	);

	sha_bsh_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.digest (digest)
	);

	assign out_busy   = (cnt_q != '0);
	assign word_valid = out_busy;

	// Digest word buffer: captured whole, shifted out word 0 first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (cmd.init_hash) begin
			cnt_q <= DIGEST_WORDS;
			idx_q <= '0;
		end else if (word_valid && word_ready) begin
			cnt_q <= cnt_q - CNT_W'(1);
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_hash) begin
			buf_q <= digest;
		end else if (word_valid && word_ready) begin
			buf_q <= {32'h0, buf_q[7:1]};
		end
	end

	assign word.digest_word = buf_q[0];
	assign word.word_index  = idx_q;
	assign word.last        = (idx_q == LAST_INDEX);

endmodule

// ===== hw/rtl/sha_bsh_datapath.sv =====
// Datapath: block shift register / message schedule, working variables, round unit, hash words.
`timescale 1ns / 1ps

module sha_bsh_datapath import sha_bsh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output logic [7:0][31:0] digest
);

	// 512-bit block window: first byte at the top, schedule word j at [511-32j -: 32]
	logic [511:0]     win_q;
	logic [7:0][31:0] v_q;
	logic [7:0][31:0] hash_q;

	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;

	// Schedule taps and the next schedule word
	assign w0    = win_q[511:480];
	assign w1    = win_q[479:448];
	assign w9    = win_q[223:192];
	assign w14   = win_q[63:32];
	assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

	// Shared round unit
	assign t1 = v_q[7] + bsig1(v_q[4]) + f_ch(v_q[4], v_q[5], v_q[6])
		+ round_k(cmd.round_idx) + w0;
	assign t2 = bsig0(v_q[0]) + f_maj(v_q[0], v_q[1], v_q[2]);

	// Block bytes shift in one per cycle while shift_en is set; rounds shift the window by a word
	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			win_q <= {win_q[503:0], cmd.shift_byte};
		end else if (cmd.round_en) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

	// Working variables a..h at index 0..7
	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			v_q <= hash_q;
		end else if (cmd.round_en) begin
			v_q <= {v_q[6], v_q[5], v_q[4], v_q[3] + t1, v_q[2], v_q[1], v_q[0], t1 + t2};
		end
	end

	// Chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_IV;
		end else if (cmd.init_hash) begin
			hash_q <= HASH_IV;
		end else if (cmd.fold_en) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	assign digest = hash_q;

endmodule

// ===== hw/rtl/sha_bsh_ctrl.sv =====
// Sequencer: byte counting, padding, round counting and finish handling.
`timescale 1ns / 1ps

module sha_bsh_ctrl import sha_bsh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	input  logic    out_busy,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [FILL_W-1:0]   fill_q;
	logic [MSG_W-1:0]    msg_q;
	logic [ROUND_W-1:0]  round_q;
	logic [LEN_W-1:0]    len_q;
	logic                fin_q;    // finish in progress
	logic                first_q;  // next pad byte is the 0x80 marker
	logic                lenph_q;  // length bytes under way, next block is the last

	logic       accept;
	logic       is_len;
	logic [7:0] pad_byte;
	logic       shift_en;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;

	// Pad byte: marker, zeros, then the bit length from the top byte down
	assign is_len   = !first_q && (lenph_q || fill_q == LEN_POS);
	assign pad_byte = first_q ? PAD_BYTE : (is_len ? len_q[LEN_W-1 -: 8] : 8'h00);
	assign shift_en = (accept && item.kind == KIND_ABSORB) || (state_q == ST_PAD);

	// Datapath commands
	always_comb begin
		cmd            = '0;
		cmd.shift_en   = shift_en;
		cmd.shift_byte = (state_q == ST_PAD) ? pad_byte : item.data_byte;
		cmd.load_vars  = shift_en && (fill_q == LAST_FILL);
		cmd.round_en   = (state_q == ST_ROUND);
		cmd.round_idx  = round_q;
		cmd.fold_en    = (state_q == ST_FOLD);
		cmd.init_hash  = (state_q == ST_DONE) && !out_busy;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			msg_q   <= '0;
			round_q <= '0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			lenph_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.kind == KIND_ABSORB) begin
							fill_q <= fill_q + FILL_W'(1);
							msg_q  <= msg_q + MSG_W'(1);
							if (fill_q == LAST_FILL) begin
								state_q <= ST_ROUND;
							end
						end else begin
							fin_q   <= 1'b1;
							first_q <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q  <= fill_q + FILL_W'(1);
					first_q <= 1'b0;
					if (is_len) begin
						lenph_q <= 1'b1;
					end
					if (fill_q == LAST_FILL) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + ROUND_W'(1);
					if (round_q == ROUND_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (lenph_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_DONE: begin
					// wait for the previous digest to drain, then restart
					if (!out_busy) begin
						fin_q   <= 1'b0;
						lenph_q <= 1'b0;
						msg_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Bit length, shifted out a byte at a time while padding
	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_FINISH) begin
			len_q <= {msg_q, 3'b000};
		end else if (state_q == ST_PAD && is_len) begin
			len_q <= {len_q[LEN_W-9:0], 8'h00};
		end
	end

`ifndef SYNTHESIS
	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ROUND) |-> (round_q == '0))
		else $error("round counter not zero outside rounds");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == ROUND_LAST) |=> (state_q == ST_FOLD))
		else $error("last round not followed by fold");

	a_len_fin: assert property (@(posedge clk) disable iff (!arst_n)
		lenph_q |-> fin_q)
		else $error("length phase outside finish");

	a_done_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (fill_q == '0 && lenph_q))
		else $error("digest ready with partial block");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for the SHA-256 byte stream hasher: directed and random messages, digest scoreboard.
`timescale 1ns / 1ps

module tb;
	import sha_bsh_pkg::*;

	localparam int RESET_CYCLES = 7;
	localparam int MAX_GAP      = 17;
	localparam int HOLD_CYCLES  = 1500;
	localparam int HOLD_AT_WORD = 40;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 300;
	localparam int TARGET_ITEMS = 450;

	// Initial hash values and round constants for the predictor
	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		item_t it;
		bit    wait_drain;	// hold this word back until all digests are out
	} feed_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_ready;
	item_t item = '0;
	logic  word_valid;
	logic  word_ready = 1'b0;
	word_t word;

	feed_t feed_q[$];
	word_t digest_q[$];
	int    errors = 0;

	// Predictor state
	logic [31:0] h_words [8];
	logic [7:0]  blk [64];
	logic [5:0]  fill;
	logic [60:0] msg_bytes;

	sha256_byte_stream_hasher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word      (word)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hasher_init();
		for (int i = 0; i < 8; i++) h_words[i] = IV[i];
		fill = '0;
		msg_bytes = '0;
	endfunction

	// One 64-round compression of blk into h_words
	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = h_words[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) h_words[i] = h_words[i] + v[i];
	endfunction

	// Advance the predictor by one accepted word; a finish queues eight digest words
	function automatic void hash_step(input item_t it);
		logic [63:0] bit_len;
		int          pos;
		word_t       dw;
		if (it.kind == KIND_ABSORB) begin
			blk[fill] = it.data_byte;
			msg_bytes = msg_bytes + 61'd1;
			fill = fill + 6'd1;
			if (fill == 6'd0) compress_block();
		end else begin
			bit_len = {msg_bytes, 3'b000};
			pos = fill;
			blk[pos] = 8'h80;
			pos++;
			if (pos > 56) begin
				for (int i = pos; i < 64; i++) blk[i] = 8'h00;
				compress_block();
				pos = 0;
			end
			for (int i = pos; i < 56; i++) blk[i] = 8'h00;
			for (int i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				dw.digest_word = h_words[i];
				dw.word_index = 3'(i);
				dw.last = (i == 7);
				digest_q.push_back(dw);
			end
			hasher_init();
		end
	endfunction

	function automatic void queue_message(input int unsigned len, input bit drain);
		feed_t f;
		for (int unsigned i = 0; i <= len; i++) begin
			f.it.kind = (i == len) ? KIND_FINISH : KIND_ABSORB;
			f.it.data_byte = 8'($urandom_range(0, 255));
			f.wait_drain = drain && (i == 0);
			feed_q.push_back(f);
		end
	endfunction

	function automatic void queue_word(input logic kind, input logic [7:0] b);
		feed_t f;
		f.it.kind = kind;
		f.it.data_byte = b;
		f.wait_drain = 1'b0;
		feed_q.push_back(f);
	endfunction

	// Sender: one word from feed_q at a time, random gap after each acceptance outside calm runs
	int gap_left = 0;
	int calm_left = 0;
	always @(posedge clk) begin
		logic  have;
		feed_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			have = item_valid;
			if (item_valid && item_ready) begin
				hash_step(item);
				have = 1'b0;
				if (calm_left > 0) begin
					calm_left--;
					gap_left = 0;
				end else begin
					gap_left = $urandom_range(0, MAX_GAP);
					if ($urandom_range(0, 39) == 0) calm_left = 40;
				end
			end
			if (!have) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (feed_q.size() > 0 &&
						!(feed_q[0].wait_drain && digest_q.size() > 0)) begin
					nxt = feed_q.pop_front();
					item <= nxt.it;
					have = 1'b1;
				end
			end
			item_valid <= have;
		end
	end

	// Receiver: checks each word, random stall per word outside calm runs, one long hold-off
	int stall_left = 0;
	int hold_left = 0;
	int words_seen = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		word_t exp_w;
		if (!arst_n) begin
			word_ready <= 1'b0;
		end else begin
			if (word_valid && word_ready) begin
				words_seen++;
				if (digest_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected digest word %h index %0d last %0b",
						$time, word.digest_word, word.word_index, word.last);
				end else begin
					exp_w = digest_q.pop_front();
					if (word.digest_word !== exp_w.digest_word) begin
						errors++;
						$display("%0t: digest_word expected %h actual %h",
							$time, exp_w.digest_word, word.digest_word);
					end
					if (word.word_index !== exp_w.word_index) begin
						errors++;
						$display("%0t: word_index expected %0d actual %0d",
							$time, exp_w.word_index, word.word_index);
					end
					if (word.last !== exp_w.last) begin
						errors++;
						$display("%0t: last expected %0b actual %0b",
							$time, exp_w.last, word.last);
					end
				end
				stall_left = (calm_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
				if (words_seen == HOLD_AT_WORD && !hold_done) begin
					hold_done = 1'b1;
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				word_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				word_ready <= 1'b0;
			end else begin
				word_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no acceptance on either channel
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (word_valid && word_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned len;
		int          r;
		int          msgs;
		hasher_init();

		// Directed: empty message with ignored data, byte extremes, "abc"
		queue_word(KIND_FINISH, 8'hff);
		queue_word(KIND_FINISH, 8'h00);
		queue_word(KIND_ABSORB, 8'h00);
		queue_word(KIND_ABSORB, 8'hff);
		queue_word(KIND_FINISH, 8'h5a);
		queue_word(KIND_ABSORB, 8'h61);
		feed_q[$].wait_drain = 1'b1;
		queue_word(KIND_ABSORB, 8'h62);
		queue_word(KIND_ABSORB, 8'h63);
		queue_word(KIND_FINISH, 8'hff);

		// Random messages; padding boundaries weighted up, a few multi-block ones
		msgs = 0;
		while (feed_q.size() < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				case ($urandom_range(0, 7))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					5: len = 65;
					6: len = 119;
					default: len = 120;
				endcase
			end else if (r < 24) begin
				len = $urandom_range(100, 200);
			end else begin
				len = $urandom_range(0, 40);
			end
			msgs++;
			queue_message(len, msgs % 9 == 8);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() > 0 || item_valid || digest_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sha_bsh_pkg.sv
hw/rtl/sha_bsh_datapath.sv
hw/rtl/sha_bsh_ctrl.sv
hw/rtl/sha256_byte_stream_hasher_core.sv
test/tb.sv
